// ----- hw/rtl/pbrle_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package pbrle_pkg;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       end_of_image;
        logic       no_data;
    } in_item_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       last_of_burst;
        logic       end_marker;
    } out_item_t;

    typedef logic [1:0] op_t;

    localparam op_t OP_PUSH = 2'd0;  // store val at buffer index cnt, no output
    localparam op_t OP_LIT  = 2'd1;  // literal packet of cnt buffered bytes
    localparam op_t OP_RUN  = 2'd2;  // repeat packet: cnt copies of val
    localparam op_t OP_END  = 2'd3;  // end-of-data marker

    typedef struct packed {
        op_t        op;
        logic [7:0] cnt;
        logic [7:0] val;
        logic       last;   // final output of the originating item
    } cmd_t;

    localparam logic [7:0] END_CODE = 8'd128;
    localparam logic [8:0] RUN_BASE = 9'd257;

    localparam int CMDQ_DEPTH = 4;
    localparam int CMDQ_PTR_W = $clog2(CMDQ_DEPTH);

endpackage

`default_nettype wire

// ----- hw/rtl/pbrle_front.sv -----
`timescale 1ns / 1ps
`default_nettype none

module pbrle_front #(
    parameter int LITERAL_MAX = 32,
    parameter int REPEAT_MAX  = 128
) (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                s_valid,
    output logic                     s_ready,
    input  wire pbrle_pkg::in_item_t s_data,
    output logic                     cmd_valid,
    input  wire logic                cmd_ready,
    output pbrle_pkg::cmd_t          cmd_data
);
    import pbrle_pkg::*;

    localparam int PC_W = $clog2(LITERAL_MAX + 1);
    localparam logic [PC_W-1:0] LIT_FULL     = PC_W'(LITERAL_MAX);
    localparam logic [7:0]      LIT_FULL_CNT = 8'(LITERAL_MAX);
    localparam logic [7:0]      RUN_LIMIT    = 8'(REPEAT_MAX);

    logic [PC_W-1:0] pc_reg, pc_next;
    logic            in_rep_reg, in_rep_next;
    logic [7:0]      rv_reg, rv_next;
    logic [7:0]      rc_reg, rc_next;
    logic [7:0]      lastb_reg, lastb_next;
    cmd_t            slot_reg [4];
    cmd_t            slot_next [4];
    logic [3:0]      slot_vld_reg, slot_vld_next;
    logic [1:0]      sel;
    logic [7:0]      b;

    function automatic cmd_t mk_cmd(op_t op, logic [7:0] cnt, logic [7:0] val, logic last);
        cmd_t c;
        c.op   = op;
        c.cnt  = cnt;
        c.val  = val;
        c.last = last;
        return c;
    endfunction

    assign s_ready   = (slot_vld_reg == 4'b0000);
    assign cmd_valid = |slot_vld_reg;
    assign cmd_data  = slot_reg[sel];
    assign b         = s_data.data_byte;

    // issue slots in order: opening packet, push, flush, end marker
    always_comb begin
        sel = 2'd0;
        for (int i = 3; i >= 0; i--) begin
            if (slot_vld_reg[i]) begin
                sel = 2'(i);
            end
        end
    end

    always_comb begin
        pc_next       = pc_reg;
        in_rep_next   = in_rep_reg;
        rv_next       = rv_reg;
        rc_next       = rc_reg;
        lastb_next    = lastb_reg;
        slot_next     = slot_reg;
        slot_vld_next = slot_vld_reg;
        if (cmd_valid && cmd_ready) begin
            slot_vld_next[sel] = 1'b0;
        end
        if (s_valid && s_ready) begin
            for (int i = 0; i < 4; i++) begin
                slot_next[i] = mk_cmd(OP_PUSH, 8'd0, 8'd0, 1'b0);
            end
            slot_vld_next = 4'b0000;
            if (!s_data.no_data) begin
                if (in_rep_reg) begin
                    if (b == rv_reg && rc_reg < RUN_LIMIT) begin
                        rc_next = rc_reg + 8'd1;
                    end else begin
                        slot_next[0]     = mk_cmd(OP_RUN, rc_reg, rv_reg, 1'b1);
                        slot_vld_next[0] = 1'b1;
                        slot_next[1]     = mk_cmd(OP_PUSH, 8'd0, b, 1'b0);
                        slot_vld_next[1] = 1'b1;
                        in_rep_next      = 1'b0;
                        rc_next          = 8'd0;
                        pc_next          = PC_W'(1);
                        lastb_next       = b;
                    end
                end else if (pc_reg != '0 && lastb_reg == b) begin
                    // equal pair: close literal before it, start a run of two
                    if (pc_reg > PC_W'(1)) begin
                        slot_next[0]     = mk_cmd(OP_LIT, 8'(pc_reg) - 8'd1, 8'd0, 1'b1);
                        slot_vld_next[0] = 1'b1;
                    end
                    pc_next     = '0;
                    in_rep_next = 1'b1;
                    rv_next     = b;
                    rc_next     = 8'd2;
                end else begin
                    if (pc_reg == LIT_FULL) begin
                        slot_next[0]     = mk_cmd(OP_LIT, LIT_FULL_CNT, 8'd0, 1'b1);
                        slot_vld_next[0] = 1'b1;
                        slot_next[1]     = mk_cmd(OP_PUSH, 8'd0, b, 1'b0);
                        pc_next          = PC_W'(1);
                    end else begin
                        slot_next[1] = mk_cmd(OP_PUSH, 8'(pc_reg), b, 1'b0);
                        pc_next      = pc_reg + PC_W'(1);
                    end
                    slot_vld_next[1] = 1'b1;
                    lastb_next       = b;
                end
            end
            if (s_data.end_of_image) begin
                slot_next[0].last = 1'b0;
                if (in_rep_next) begin
                    slot_next[2]     = mk_cmd(OP_RUN, rc_next, rv_next, 1'b0);
                    slot_vld_next[2] = 1'b1;
                end else if (pc_next != '0) begin
                    slot_next[2]     = mk_cmd(OP_LIT, 8'(pc_next), 8'd0, 1'b0);
                    slot_vld_next[2] = 1'b1;
                end
                slot_next[3]     = mk_cmd(OP_END, 8'd0, END_CODE, 1'b1);
                slot_vld_next[3] = 1'b1;
                pc_next          = '0;
                in_rep_next      = 1'b0;
                rv_next          = 8'd0;
                rc_next          = 8'd0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pc_reg       <= '0;
            in_rep_reg   <= 1'b0;
            rv_reg       <= 8'd0;
            rc_reg       <= 8'd0;
            slot_vld_reg <= 4'b0000;
        end else begin
            pc_reg       <= pc_next;
            in_rep_reg   <= in_rep_next;
            rv_reg       <= rv_next;
            rc_reg       <= rc_next;
            slot_vld_reg <= slot_vld_next;
        end
        lastb_reg <= lastb_next;
        slot_reg  <= slot_next;
    end

`ifndef SYNTH
    a_end_queues_marker: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && s_data.end_of_image |=> slot_vld_reg[3])
        else $error("end of image did not queue an end marker");
    a_run_bounded: assert property (@(posedge aclk) disable iff (!aresetn)
        in_rep_reg |-> (rc_reg >= 8'd2 && rc_reg <= RUN_LIMIT && pc_reg == '0))
        else $error("run state out of range");
`endif

endmodule

`default_nettype wire

// ----- hw/rtl/pbrle_queue.sv -----
`timescale 1ns / 1ps
`default_nettype none

module pbrle_queue (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            in_valid,
    output logic                 in_ready,
    input  wire pbrle_pkg::cmd_t in_data,
    output logic                 out_valid,
    input  wire logic            out_ready,
    output pbrle_pkg::cmd_t      out_data
);
    import pbrle_pkg::*;

    cmd_t                  entry_reg [CMDQ_DEPTH];
    logic [CMDQ_PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CMDQ_PTR_W:0]   count_reg, count_next;
    logic                  push, pop;

    assign in_ready  = (count_reg != (CMDQ_PTR_W + 1)'(CMDQ_DEPTH));
    assign out_valid = (count_reg != '0);
    assign out_data  = entry_reg[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    always_comb begin
        count_next = count_reg;
        if (push && !pop) begin
            count_next = count_reg + (CMDQ_PTR_W + 1)'(1);
        end else if (pop && !push) begin
            count_next = count_reg - (CMDQ_PTR_W + 1)'(1);
        end
    end

    // pointers wrap naturally: depth is a power of two
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + CMDQ_PTR_W'(1);
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + CMDQ_PTR_W'(1);
            end
            count_reg <= count_next;
        end
        if (push) begin
            entry_reg[wr_ptr_reg] <= in_data;
        end
    end

`ifndef SYNTH
    a_count_bounded: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= (CMDQ_PTR_W + 1)'(CMDQ_DEPTH))
        else $error("command queue overflow");
`endif

endmodule

`default_nettype wire

// ----- hw/rtl/pbrle_back.sv -----
`timescale 1ns / 1ps
`default_nettype none

module pbrle_back #(
    parameter int LITERAL_MAX = 32
) (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            cmd_valid,
    output logic                 cmd_ready,
    input  wire pbrle_pkg::cmd_t cmd_data,
    output logic                 m_valid,
    input  wire logic            m_ready,
    output pbrle_pkg::out_item_t m_data
);
    import pbrle_pkg::*;

    localparam int IDX_W = (LITERAL_MAX > 1) ? $clog2(LITERAL_MAX) : 1;

    localparam logic [1:0] B_IDLE = 2'd0;
    localparam logic [1:0] B_HDR  = 2'd1;
    localparam logic [1:0] B_LIT  = 2'd2;
    localparam logic [1:0] B_RUN  = 2'd3;

    logic [7:0]       buf_mem [LITERAL_MAX];
    logic [7:0]       rd_data_reg;
    logic [1:0]       state_reg, state_next;
    cmd_t             cmd_reg, cmd_next;
    logic [IDX_W-1:0] idx_reg, idx_next;
    logic             m_valid_reg, m_valid_next;
    out_item_t        m_data_reg, m_data_next;
    logic             out_free;
    logic             wr_en;
    logic             lit_done;

    assign out_free  = !m_valid_reg || m_ready;
    assign cmd_ready = (state_reg == B_IDLE);
    assign m_valid   = m_valid_reg;
    assign m_data    = m_data_reg;
    assign lit_done  = ((8'(idx_reg) + 8'd1) == cmd_reg.cnt);

    always_comb begin
        state_next   = state_reg;
        cmd_next     = cmd_reg;
        idx_next     = idx_reg;
        m_valid_next = m_valid_reg && !m_ready;
        m_data_next  = m_data_reg;
        wr_en        = 1'b0;
        case (state_reg)
            B_IDLE: begin
                if (cmd_valid) begin
                    if (cmd_data.op == OP_PUSH) begin
                        wr_en = 1'b1;
                    end else begin
                        cmd_next   = cmd_data;
                        idx_next   = '0;
                        state_next = B_HDR;
                    end
                end
            end
            B_HDR: begin
                if (out_free) begin
                    m_valid_next               = 1'b1;
                    m_data_next.last_of_burst  = 1'b0;
                    m_data_next.end_marker     = 1'b0;
                    case (cmd_reg.op)
                        OP_LIT: begin
                            m_data_next.out_byte = cmd_reg.cnt - 8'd1;
                            state_next           = B_LIT;
                        end
                        OP_RUN: begin
                            m_data_next.out_byte = 8'(RUN_BASE - {1'b0, cmd_reg.cnt});
                            state_next           = B_RUN;
                        end
                        default: begin
                            m_data_next.out_byte      = END_CODE;
                            m_data_next.last_of_burst = cmd_reg.last;
                            m_data_next.end_marker    = 1'b1;
                            state_next                = B_IDLE;
                        end
                    endcase
                end
            end
            B_LIT: begin
                if (out_free) begin
                    m_valid_next              = 1'b1;
                    m_data_next.out_byte      = rd_data_reg;
                    m_data_next.last_of_burst = cmd_reg.last && lit_done;
                    m_data_next.end_marker    = 1'b0;
                    if (lit_done) begin
                        idx_next   = '0;
                        state_next = B_IDLE;
                    end else begin
                        idx_next = idx_reg + IDX_W'(1);
                    end
                end
            end
            B_RUN: begin
                if (out_free) begin
                    m_valid_next              = 1'b1;
                    m_data_next.out_byte      = cmd_reg.val;
                    m_data_next.last_of_burst = cmd_reg.last;
                    m_data_next.end_marker    = 1'b0;
                    state_next                = B_IDLE;
                end
            end
            default: begin
                state_next = B_IDLE;
            end
        endcase
    end

    // read data is registered from idx_next, so it lines up with idx_reg
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            buf_mem[cmd_data.cnt[IDX_W-1:0]] <= cmd_data.val;
        end
        rd_data_reg <= buf_mem[idx_next];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= B_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
        cmd_reg    <= cmd_next;
        idx_reg    <= idx_next;
        m_data_reg <= m_data_next;
    end

`ifndef SYNTH
    a_marker_closes_burst: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && m_data_reg.end_marker |->
            (m_data_reg.last_of_burst && m_data_reg.out_byte == END_CODE))
        else $error("end marker malformed");
    a_lit_state_op: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == B_LIT |-> (cmd_reg.op == OP_LIT && cmd_reg.cnt != 8'd0))
        else $error("literal emission without a literal command");
`endif

endmodule

`default_nettype wire

// ----- hw/rtl/packbits_run_length_encoder_unit.sv -----
// An item goes through the front end's slots, the command queue and the back end's command
// register before its first result is registered, after any buffer write ahead of it;
// output stalls hold it. A new item is taken once all of the last one's commands are
// queued: a buffered byte queues a write and any packet it closes, a byte extending a run
// none, a byte ending the image up to four. Output: a literal is a header and its bytes,
// a run a header and its value. Reset: aresetn, synchronous, active low.
`timescale 1ns / 1ps
`default_nettype none

module packbits_run_length_encoder_unit #(
    parameter int LITERAL_MAX = 32,
    parameter int REPEAT_MAX  = 128
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_valid,
    output logic                      s_ready,
    input  wire pbrle_pkg::in_item_t  s_data,
    output logic                      m_valid,
    input  wire logic                 m_ready,
    output pbrle_pkg::out_item_t      m_data
);
    import pbrle_pkg::*;

    logic fq_valid, fq_ready;
    cmd_t fq_data;
    logic qb_valid, qb_ready;
    cmd_t qb_data;

    pbrle_front #(
        .LITERAL_MAX (LITERAL_MAX),
        .REPEAT_MAX  (REPEAT_MAX)
    ) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .cmd_valid (fq_valid),
        .cmd_ready (fq_ready),
        .cmd_data  (fq_data)
    );

    pbrle_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (fq_valid),
        .in_ready  (fq_ready),
        .in_data   (fq_data),
        .out_valid (qb_valid),
        .out_ready (qb_ready),
        .out_data  (qb_data)
    );

    pbrle_back #(
        .LITERAL_MAX (LITERAL_MAX)
    ) u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd_valid (qb_valid),
        .cmd_ready (qb_ready),
        .cmd_data  (qb_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

endmodule

`default_nettype wire

// ----- verif/packbits_run_length_encoder_unit_check.sv -----
`timescale 1ns / 1ps

module packbits_run_length_encoder_unit_check #(
    parameter int LITERAL_MAX = 32,
    parameter int REPEAT_MAX  = 128
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    input  logic                s_ready,
    input  pbrle_pkg::in_item_t  s_data,
    input  logic                m_valid,
    input  logic                m_ready,
    input  pbrle_pkg::out_item_t m_data,
    output int                  mismatch_total,
    output int                  outstanding,
    output int                  bytes_checked,
    output int                  images_closed,
    output int                  full_literals,
    output int                  capped_runs
);
    import pbrle_pkg::*;

    logic [7:0] lit_buf [LITERAL_MAX];
    int         lit_cnt = 0;
    logic       run_on = 1'b0;
    logic [7:0] run_val = 8'd0;
    int         run_len = 0;

    out_item_t  encoded_stream [$];
    out_item_t  burst [$];

    task automatic put_byte(input logic [7:0] b, input logic marker);
        out_item_t r;
        r = {b, 1'b0, marker};
        burst = {burst, r};
    endtask

    task automatic flush_literal(input int n);
        if (n > 0) begin
            put_byte(8'(n - 1), 1'b0);
            for (int i = 0; i < n; i++) put_byte(lit_buf[i], 1'b0);
        end
    endtask

    task automatic flush_run();
        put_byte(8'(RUN_BASE - 9'(run_len)), 1'b0);
        put_byte(run_val, 1'b0);
    endtask

    // Work out every encoded byte that one accepted item causes.
    task automatic encode_item(input in_item_t it);
        out_item_t r;
        logic [7:0] b;
        b = it.data_byte;
        burst.delete();
        if (!it.no_data) begin
            if (run_on) begin
                if (b == run_val && run_len < REPEAT_MAX) begin
                    run_len++;
                end else begin
                    if (b == run_val) capped_runs++;
                    flush_run();
                    run_on = 1'b0;
                    run_len = 0;
                    lit_buf[0] = b;
                    lit_cnt = 1;
                end
            end else if (lit_cnt > 0 && lit_buf[lit_cnt - 1] == b) begin
                // close the literal before the pair, then count the run
                flush_literal(lit_cnt - 1);
                lit_cnt = 0;
                run_on = 1'b1;
                run_val = b;
                run_len = 2;
            end else begin
                if (lit_cnt >= LITERAL_MAX) begin
                    full_literals++;
                    flush_literal(LITERAL_MAX);
                    lit_cnt = 0;
                end
                lit_buf[lit_cnt] = b;
                lit_cnt++;
            end
        end
        if (it.end_of_image) begin
            if (run_on) flush_run();
            else flush_literal(lit_cnt);
            put_byte(END_CODE, 1'b1);
            images_closed++;
            lit_cnt = 0;
            run_on = 1'b0;
            run_val = 8'd0;
            run_len = 0;
        end
        foreach (burst[i]) begin
            r = burst[i];
            r.last_of_burst = (i == burst.size() - 1);
            encoded_stream = {encoded_stream, r};
        end
    endtask

    always @(posedge aclk) begin
        out_item_t want;
        if (!aresetn) begin
            encoded_stream.delete();
            lit_cnt = 0;
            run_on = 1'b0;
            run_val = 8'd0;
            run_len = 0;
        end else begin
            if (m_valid && m_ready) begin
                if (encoded_stream.size() == 0) begin
                    mismatch_total++;
                    $display("%0t: got byte/last/marker %h/%b/%b, expected nothing", $time,
                             m_data.out_byte, m_data.last_of_burst, m_data.end_marker);
                end else begin
                    want = encoded_stream.pop_front();
                    bytes_checked++;
                    if (m_data.out_byte != want.out_byte
                            || m_data.last_of_burst != want.last_of_burst
                            || m_data.end_marker != want.end_marker) begin
                        mismatch_total++;
                        $display("%0t: expected byte/last/marker %h/%b/%b, got %h/%b/%b",
                                 $time, want.out_byte, want.last_of_burst, want.end_marker,
                                 m_data.out_byte, m_data.last_of_burst, m_data.end_marker);
                    end
                end
            end
            if (s_valid && s_ready) encode_item(s_data);
        end
        outstanding <= encoded_stream.size();
    end

endmodule

// ----- verif/packbits_run_length_encoder_unit_test.sv -----
`timescale 1ns / 1ps

module packbits_run_length_encoder_unit_test;
    import pbrle_pkg::*;

    localparam int RANDOM_ITEMS = 420;

    logic      aclk = 1'b0;
    logic      aresetn = 1'b0;
    logic      s_valid = 1'b0;
    logic      s_ready;
    in_item_t  s_data = '0;
    logic      m_valid;
    logic      m_ready = 1'b0;
    out_item_t m_data;

    logic      steady = 1'b0;
    int        fed_items = 0;
    int        random_start;

    int mismatch_total, outstanding, bytes_checked, images_closed;
    int full_literals, capped_runs;

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    packbits_run_length_encoder_unit uut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    packbits_run_length_encoder_unit_check checker_i (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_data         (s_data),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_data         (m_data),
        .mismatch_total (mismatch_total),
        .outstanding    (outstanding),
        .bytes_checked  (bytes_checked),
        .images_closed  (images_closed),
        .full_literals  (full_literals),
        .capped_runs    (capped_runs)
    );

    always @(posedge aclk) begin
        m_ready <= steady || ($urandom_range(0, 99) >= 35);
    end

    task automatic send_item(input logic [7:0] b, input logic eoi, input logic nd);
        in_item_t it;
        it = {b, eoi, nd};
        if (!steady) begin
            while ($urandom_range(0, 99) < 35) begin
                s_valid <= 1'b0;
                @(posedge aclk);
            end
        end
        s_valid <= 1'b1;
        s_data <= it;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        if (!nd || eoi) fed_items++;
    endtask

    // Build one image from runs, literal stretches and noise, then feed it.
    task automatic make_image();
        in_item_t   img [$];
        in_item_t   it;
        int         segs;
        int         len;
        int         kind;
        logic       narrow;
        logic [7:0] b;
        segs = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 5);
        repeat (segs) begin
            kind = $urandom_range(0, 9);
            if (kind <= 3) begin
                len = ($urandom_range(0, 15) == 0) ? $urandom_range(120, 140)
                                                   : $urandom_range(2, 8);
                b = 8'($urandom);
                repeat (len) begin
                    it = {b, 1'b0, 1'b0};
                    img = {img, it};
                end
            end else if (kind <= 6) begin
                len = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 70)
                                                  : $urandom_range(1, 12);
                narrow = 1'($urandom_range(0, 1));
                repeat (len) begin
                    b = narrow ? 8'($urandom_range(0, 3)) : 8'($urandom);
                    it = {b, 1'b0, 1'b0};
                    img = {img, it};
                end
            end else if (kind == 7) begin
                repeat ($urandom_range(1, 4)) begin
                    it = {8'($urandom), 1'b0, 1'($urandom_range(0, 1))};
                    img = {img, it};
                end
            end else begin
                // no two neighbors equal: can fill the literal buffer
                len = $urandom_range(28, 40);
                b = 8'($urandom);
                repeat (len) begin
                    b = b + 8'($urandom_range(1, 255));
                    it = {b, 1'b0, 1'b0};
                    img = {img, it};
                end
            end
        end
        if (img.size() > 0 && $urandom_range(0, 1)) begin
            it = img.pop_back();
            it.end_of_image = 1'b1;
            img = {img, it};
        end else begin
            it = {8'($urandom), 1'b1, 1'b1};
            img = {img, it};
        end
        foreach (img[i]) send_item(img[i].data_byte, img[i].end_of_image, img[i].no_data);
    endtask

    initial begin
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        send_item(8'h00, 1'b1, 1'b1);     // empty image
        send_item(8'hA5, 1'b0, 1'b1);     // no byte, no end: ignored
        send_item(8'h00, 1'b1, 1'b0);     // lone byte
        send_item(8'hFF, 1'b0, 1'b0);     // pair with nothing buffered
        send_item(8'hFF, 1'b0, 1'b0);
        send_item(8'h5A, 1'b1, 1'b1);
        send_item(8'h12, 1'b0, 1'b0);     // literal, run, run broken
        send_item(8'h34, 1'b0, 1'b0);
        send_item(8'h34, 1'b0, 1'b0);
        send_item(8'h34, 1'b0, 1'b0);
        send_item(8'h56, 1'b1, 1'b0);
        send_item(8'h80, 1'b0, 1'b0);
        send_item(8'h7F, 1'b0, 1'b0);
        send_item(8'h01, 1'b0, 1'b0);
        send_item(8'hFE, 1'b1, 1'b0);
        send_item(8'h55, 1'b0, 1'b0);     // pair on the last byte
        send_item(8'h55, 1'b1, 1'b0);
        send_item(8'h33, 1'b0, 1'b0);     // run closed by an empty end item
        send_item(8'h33, 1'b0, 1'b0);
        send_item(8'h33, 1'b0, 1'b0);
        send_item(8'hC3, 1'b1, 1'b1);

        random_start = fed_items;
        while (fed_items - random_start < RANDOM_ITEMS) begin
            steady <= (fed_items - random_start >= 180) && (fed_items - random_start < 280);
            make_image();
        end
        s_valid <= 1'b0;
        steady <= 1'b0;

        @(posedge aclk);
        while (outstanding != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);

        $display("covered %0d items in %0d images, %0d encoded bytes checked", fed_items,
                 images_closed, bytes_checked);
        $display("%0d full literal buffers, %0d runs at maximum length", full_literals,
                 capped_runs);
        if (mismatch_total == 0) begin
            $display("packbits_run_length_encoder_unit_test: clean");
        end else begin
            $display("packbits_run_length_encoder_unit_test: errors");
        end
        $finish;
    end

    initial begin
        #1000000;
        $display("packbits_run_length_encoder_unit_test: errors");
        $finish;
    end

endmodule
